### src/rlfm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the region lock FIFO manager.
// Used by the table and the core modules; depends on nothing else.
package rlfm_pkg;

  localparam int unsigned TASK_W   = 6;
  localparam int unsigned REGION_W = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CFG_W    = 5;

  localparam logic [CFG_W-1:0]    CFG_RESET    = 5'd16;
  localparam logic [REGION_W-1:0] REGION_DUMMY = 6'h3F;

  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_GRANTED       = 3'd0,
    ST_QUEUED        = 3'd1,
    ST_FREED         = 3'd2,
    ST_HANDOVER      = 3'd3,
    ST_BAD_REGION    = 3'd4,
    ST_ALREADY_OWNER = 3'd5,
    ST_NOT_OWNER     = 3'd6,
    ST_QUEUE_FULL    = 3'd7
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_id;
  } owner_t;

endpackage

### src/rlfm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module rlfm_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rlfm_table.sv
`timescale 1ns / 1ps
// Per-region state: owner, ring head, ring tail and waiter count.
// One combinational read port, one write port; uses rlfm_pkg.
module rlfm_table import rlfm_pkg::*; #(
  parameter int unsigned NUM_REGIONS = 16,
  parameter int unsigned NUM_TASKS   = 64,
  localparam int unsigned RIDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1,
  localparam int unsigned PTR_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1,
  localparam int unsigned CNT_W  = $clog2(NUM_TASKS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RIDX_W-1:0] rd_idx_i,
  output owner_t            rd_owner_o,
  output logic [PTR_W-1:0]  rd_head_o,
  output logic [PTR_W-1:0]  rd_tail_o,
  output logic [CNT_W-1:0]  rd_count_o,
  input  logic              wr_en_i,
  input  logic [RIDX_W-1:0] wr_idx_i,
  input  owner_t            wr_owner_i,
  input  logic [PTR_W-1:0]  wr_head_i,
  input  logic [PTR_W-1:0]  wr_tail_i,
  input  logic [CNT_W-1:0]  wr_count_i
);

  owner_t           owner_q [NUM_REGIONS];
  logic [PTR_W-1:0] head_q  [NUM_REGIONS];
  logic [PTR_W-1:0] tail_q  [NUM_REGIONS];
  logic [CNT_W-1:0] count_q [NUM_REGIONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        owner_q[i] <= '0;
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      owner_q[wr_idx_i] <= wr_owner_i;
      head_q[wr_idx_i]  <= wr_head_i;
      tail_q[wr_idx_i]  <= wr_tail_i;
      count_q[wr_idx_i] <= wr_count_i;
    end
  end

  assign rd_owner_o = owner_q[rd_idx_i];
  assign rd_head_o  = head_q[rd_idx_i];
  assign rd_tail_o  = tail_q[rd_idx_i];
  assign rd_count_o = count_q[rd_idx_i];

endmodule

### src/region_lock_fifo_manager_core.sv
`timescale 1ns / 1ps
// Region lock manager with a FIFO of waiting tasks per region.
// Each accepted item passes the input register, the region lookup with ring
// read and the result register, in that order.
// Throughput: one item per cycle; a stalled result holds the stages behind it.
// Reset clears all owners, ring pointers and counts at once; the waiting ring
// itself is not cleared, since an entry is only read after it was written.
module region_lock_fifo_manager_core import rlfm_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned MAX_TASKS   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [TASK_W-1:0]   task_id_i,
  input  logic [REGION_W-1:0] region_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [TASK_W-1:0]   next_owner_o,
  output logic                is_owner_o
);

  localparam int unsigned RIDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned PTR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int unsigned DEPTH  = MAX_REGIONS * MAX_TASKS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [RIDX_W-1:0] idx,
                                                  input logic [PTR_W-1:0] ptr);
    ring_addr = ADDR_W'(32'(idx) * 32'(MAX_TASKS) + 32'(ptr));
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    advance = (ptr == PTR_W'(MAX_TASKS - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Configuration register.
  logic [CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Handshake control.
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic out_free, s1_fire, s1_free, s0_move, in_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign s0_move    = s0_valid_q && s1_free;
  assign in_ready_o = !s0_valid_q || s1_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Stage 0: accepted item and region decode.
  logic [OP_W-1:0]     s0_op_q;
  logic [TASK_W-1:0]   s0_task_q;
  logic [REGION_W-1:0] s0_rid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_op_q   <= op_i;
      s0_task_q <= task_id_i;
      s0_rid_q  <= region_id_i;
    end
  end

  logic              s0_dummy, s0_bad;
  logic [4:0]        s0_rid5, s0_rid_m1;
  logic [RIDX_W-1:0] s0_idx;

  assign s0_rid5   = s0_rid_q[4:0];
  assign s0_rid_m1 = s0_rid5 - 5'd1;
  assign s0_idx    = RIDX_W'(s0_rid_m1);
  assign s0_dummy  = (s0_rid_q == REGION_DUMMY);
  // A region is valid when it is positive, within the register and the table.
  assign s0_bad    = !(!s0_rid_q[REGION_W-1] && (s0_rid5 != 5'd0) &&
                       (s0_rid5 <= cfg_q) && (32'(s0_rid5) <= 32'(MAX_REGIONS)));

  // Region table.
  owner_t           tbl_owner;
  logic [PTR_W-1:0] tbl_head, tbl_tail;
  logic [CNT_W-1:0] tbl_count;

  logic              upd_en;
  logic [RIDX_W-1:0] s1_idx_q;
  owner_t            upd_owner;
  logic [PTR_W-1:0]  upd_head, upd_tail;
  logic [CNT_W-1:0]  upd_count;

  rlfm_table #(
    .NUM_REGIONS (MAX_REGIONS),
    .NUM_TASKS   (MAX_TASKS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (s0_idx),
    .rd_owner_o (tbl_owner),
    .rd_head_o  (tbl_head),
    .rd_tail_o  (tbl_tail),
    .rd_count_o (tbl_count),
    .wr_en_i    (upd_en),
    .wr_idx_i   (s1_idx_q),
    .wr_owner_i (upd_owner),
    .wr_head_i  (upd_head),
    .wr_tail_i  (upd_tail),
    .wr_count_i (upd_count)
  );

  // The item ahead may be updating this same region at this edge.
  logic             fwd;
  owner_t           snap_owner;
  logic [PTR_W-1:0] snap_head, snap_tail;
  logic [CNT_W-1:0] snap_count;

  assign fwd        = upd_en && (s1_idx_q == s0_idx);
  assign snap_owner = fwd ? upd_owner : tbl_owner;
  assign snap_head  = fwd ? upd_head  : tbl_head;
  assign snap_tail  = fwd ? upd_tail  : tbl_tail;
  assign snap_count = fwd ? upd_count : tbl_count;

  // Waiting ring: the head entry is read as the item moves to stage 1.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [TASK_W-1:0] ram_wdata, ram_rdata;

  assign ram_raddr = ring_addr(s0_idx, snap_head);

  rlfm_ram #(
    .WIDTH (TASK_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s0_move),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Stage 1: region snapshot and ring head.
  logic [OP_W-1:0]   s1_op_q;
  logic [TASK_W-1:0] s1_task_q;
  logic              s1_dummy_q, s1_bad_q;
  owner_t            s1_owner_q;
  logic [PTR_W-1:0]  s1_head_q, s1_tail_q;
  logic [CNT_W-1:0]  s1_count_q;
  logic              s1_byp_q;
  logic [TASK_W-1:0] s1_byp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_move) begin
      s1_op_q       <= s0_op_q;
      s1_task_q     <= s0_task_q;
      s1_dummy_q    <= s0_dummy;
      s1_bad_q      <= s0_bad;
      s1_idx_q      <= s0_idx;
      s1_owner_q    <= snap_owner;
      s1_head_q     <= snap_head;
      s1_tail_q     <= snap_tail;
      s1_count_q    <= snap_count;
      // A write to the entry being read returns the old data, so keep the new.
      s1_byp_q      <= ram_we && (ram_waddr == ram_raddr);
      s1_byp_data_q <= ram_wdata;
    end
  end

  logic [TASK_W-1:0] ring_head_task;
  logic              owns, upd_req;
  status_e           res_status;
  logic [TASK_W-1:0] res_next;
  logic              res_own;
  logic              enq;

  assign ring_head_task = s1_byp_q ? s1_byp_data_q : ram_rdata;
  assign owns = s1_owner_q.valid && (s1_owner_q.task_id == s1_task_q);

  always_comb begin
    res_status = ST_GRANTED;
    res_next   = '0;
    res_own    = 1'b0;
    upd_req    = 1'b0;
    enq        = 1'b0;
    upd_owner  = s1_owner_q;
    upd_head   = s1_head_q;
    upd_tail   = s1_tail_q;
    upd_count  = s1_count_q;
    priority if (s1_dummy_q) begin
      unique case (s1_op_q)
        OP_BEGIN: res_status = ST_GRANTED;
        OP_END:   res_status = ST_FREED;
        default: begin
          res_status = ST_GRANTED;
          res_own    = 1'b1;
        end
      endcase
    end else if (s1_bad_q) begin
      res_status = ST_BAD_REGION;
    end else begin
      unique case (s1_op_q)
        OP_BEGIN: begin
          priority if (owns) begin
            res_status = ST_ALREADY_OWNER;
          end else if (!s1_owner_q.valid) begin
            res_status        = ST_GRANTED;
            upd_req           = 1'b1;
            upd_owner.valid   = 1'b1;
            upd_owner.task_id = s1_task_q;
          end else if (s1_count_q == CNT_W'(MAX_TASKS)) begin
            res_status = ST_QUEUE_FULL;
          end else begin
            res_status = ST_QUEUED;
            upd_req    = 1'b1;
            enq        = 1'b1;
            upd_tail   = advance(s1_tail_q);
            upd_count  = s1_count_q + CNT_W'(1);
          end
        end
        OP_END: begin
          priority if (!owns) begin
            res_status = ST_NOT_OWNER;
          end else if (s1_count_q == '0) begin
            res_status = ST_FREED;
            upd_req    = 1'b1;
            upd_owner  = '0;
          end else begin
            res_status        = ST_HANDOVER;
            res_next          = ring_head_task;
            upd_req           = 1'b1;
            upd_owner.task_id = ring_head_task;
            upd_head          = advance(s1_head_q);
            upd_count         = s1_count_q - CNT_W'(1);
          end
        end
        default: begin
          res_status = ST_GRANTED;
          res_own    = owns;
        end
      endcase
    end
  end

  assign upd_en    = s1_fire && upd_req;
  assign ram_we    = s1_fire && enq;
  assign ram_waddr = ring_addr(s1_idx_q, s1_tail_q);
  assign ram_wdata = s1_task_q;

  // Result register.
  status_e           status_q;
  logic [TASK_W-1:0] next_owner_q;
  logic              is_owner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q     <= res_status;
      next_owner_q <= res_next;
      is_owner_q   <= res_own;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign next_owner_o = next_owner_q;
  assign is_owner_o   = is_owner_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_count_q <= CNT_W'(MAX_TASKS)))
    else $error("waiter count above queue capacity");

  a_next_only_on_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_HANDOVER)) |-> (next_owner_q == '0))
    else $error("next owner set without a handover");

  a_owner_only_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_owner_q) |-> (status_q == ST_GRANTED))
    else $error("ownership answer with a non-grant status");

  a_enqueue_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((s1_op_q == OP_BEGIN) && !s1_dummy_q && !s1_bad_q &&
                s1_owner_q.valid))
    else $error("ring write outside a queued begin request");
`endif

endmodule
